FILE: src/lcsd_pkg.sv
// shared types and constants of the led cube scan driver
// item structs for the command and result channels, op codes, default cube edge
`default_nettype none

package lcsd_pkg;

  localparam int EDGE_DEFAULT = 8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] coord_x;
    logic signed [7:0] coord_y;
    logic signed [7:0] coord_z;
    logic [15:0]       repeat_count;
  } cmd_t;

  typedef struct packed {
    logic       serial_bit;
    logic       shift_pulse;
    logic       latch_pulse;
    logic [7:0] level_enable;
    logic [2:0] mapped_x;
    logic [2:0] mapped_y;
    logic [2:0] mapped_z;
    logic       busy_res;
  } res_t;

endpackage

`default_nettype wire

FILE: src/led_cube_scan_driver_unit.sv
// led cube scan driver: an accepted item passes s1, then s2 with the registered voxel
// memory read, then the result register; no item is taken while s1 is full or s2 stalls
// after reset a clearing pass over all EDGE^3 voxel locations holds cmd_stall high
// reset clears scan position, level, drive lines and frame count; uses lcsd_pkg, lcsd_voxel_mem
`default_nettype none

module led_cube_scan_driver_unit #(
  parameter int EDGE = lcsd_pkg::EDGE_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire lcsd_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output lcsd_pkg::res_t     res
);

  import lcsd_pkg::*;

  localparam int LEVEL_BITS = EDGE * EDGE;
  localparam int STORE_SIZE = EDGE * EDGE * EDGE;
  localparam int AW = $clog2(STORE_SIZE);
  localparam int CW = $clog2(EDGE);
  localparam int PW = $clog2(LEVEL_BITS + 1);

  // wrap a non-negative coordinate into the cube, one conditional subtract per step; a negative one maps to EDGE-1
  function automatic logic [CW-1:0] map_coord(input logic signed [7:0] v);
    logic [11:0] r;
    r = {5'b0, v[6:0]};
    for (int k = 6; k >= 0; k--) begin
      if (r >= 12'(EDGE << k)) begin
        r = r - 12'(EDGE << k);
      end
    end
    if (v[7]) begin
      r = 12'(EDGE - 1);
    end
    return CW'(r);
  endfunction

  logic          cmd_accept;
  logic          s2_go;
  logic          mem_ready;
  logic          mem_wr;
  logic          mem_rd;
  logic [AW-1:0] mem_addr;
  logic          mem_wdata;
  logic          mem_rdata;

  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [CW-1:0] s1_mx;
  logic [CW-1:0] s1_my;
  logic [CW-1:0] s1_mz;
  logic [15:0]   s1_rc;

  logic          s2_valid;
  logic          s2_rd;
  res_t          s2_res;
  res_t          s2_res_next;
  res_t          res_next;

  logic [PW-1:0]   bit_pos;
  logic [PW-1:0]   bit_pos_next;
  logic [CW-1:0]   cur_level;
  logic [CW-1:0]   cur_level_next;
  logic [CW-1:0]   prev_level;
  logic [EDGE-1:0] level_lines;
  logic [EDGE-1:0] level_lines_next;
  logic [15:0]     frames_left;
  logic [15:0]     frames_left_next;
  logic [7:0]      lines_out;
  logic            shift_now;
  logic            latch_now;
  logic [AW-1:0]   vox_idx;
  logic [AW-1:0]   scan_idx;

  assign cmd_accept = cmd_valid && !cmd_stall;
  assign s2_go      = s2_valid && (!res_valid || !res_stall);
  assign cmd_stall  = !mem_ready || s1_valid || (s2_valid && !s2_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_accept;
    end
    if (cmd_accept) begin
      s1_op <= cmd.op;
      s1_mx <= map_coord(cmd.coord_x);
      s1_my <= map_coord(cmd.coord_y);
      s1_mz <= map_coord(cmd.coord_z);
      s1_rc <= cmd.repeat_count;
    end
  end

  assign vox_idx  = AW'(s1_mz * LEVEL_BITS + s1_my * EDGE + s1_mx);
  assign scan_idx = AW'(cur_level * LEVEL_BITS + bit_pos);
  assign prev_level = (cur_level == '0) ? CW'(EDGE - 1) : cur_level - 1'b1;

  always_comb begin
    bit_pos_next     = bit_pos;
    cur_level_next   = cur_level;
    level_lines_next = level_lines;
    frames_left_next = frames_left;
    mem_wr           = 1'b0;
    mem_rd           = 1'b0;
    mem_addr         = (s1_op == OP_TICK) ? scan_idx : vox_idx;
    mem_wdata        = (s1_op == OP_SET);
    shift_now        = 1'b0;
    latch_now        = 1'b0;
    if (s1_valid) begin
      unique case (s1_op) inside
        OP_SET, OP_CLEAR: begin
          mem_wr = 1'b1;
        end
        OP_START: begin
          frames_left_next = s1_rc;
          bit_pos_next     = '0;
          cur_level_next   = '0;
        end
        OP_TICK: begin
          if (frames_left != '0) begin
            if (bit_pos < PW'(LEVEL_BITS)) begin
              mem_rd       = 1'b1;
              shift_now    = 1'b1;
              bit_pos_next = bit_pos + 1'b1;
            end else begin
              latch_now                    = 1'b1;
              level_lines_next[prev_level] = 1'b0;
              level_lines_next[cur_level]  = 1'b1;
              bit_pos_next                 = '0;
              if (cur_level == CW'(EDGE - 1)) begin
                cur_level_next   = '0;
                frames_left_next = frames_left - 1'b1;
              end else begin
                cur_level_next = cur_level + 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  generate
    if (EDGE >= 8) begin : g_lines_wide
      assign lines_out = level_lines_next[7:0];
    end else begin : g_lines_narrow
      assign lines_out = 8'(level_lines_next);
    end
  endgenerate

  always_comb begin
    s2_res_next              = '0;
    s2_res_next.shift_pulse  = shift_now;
    s2_res_next.latch_pulse  = latch_now;
    s2_res_next.level_enable = lines_out;
    s2_res_next.busy_res     = (frames_left_next != '0);
    if (s1_op == OP_SET || s1_op == OP_CLEAR) begin
      s2_res_next.mapped_x = 3'(s1_mx);
      s2_res_next.mapped_y = 3'(s1_my);
      s2_res_next.mapped_z = 3'(s1_mz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_pos     <= '0;
      cur_level   <= '0;
      level_lines <= '0;
      frames_left <= '0;
      s2_valid    <= 1'b0;
    end else begin
      bit_pos     <= bit_pos_next;
      cur_level   <= cur_level_next;
      level_lines <= level_lines_next;
      frames_left <= frames_left_next;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
    if (s1_valid) begin
      s2_res <= s2_res_next;
      s2_rd  <= mem_rd;
    end
  end

  always_comb begin
    res_next            = s2_res;
    res_next.serial_bit = s2_rd && mem_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s2_go) begin
      res <= res_next;
    end
  end

  lcsd_voxel_mem #(
    .DEPTH(STORE_SIZE)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .ready(mem_ready),
    .wr_en(mem_wr),
    .rd_en(mem_rd),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

FILE: src/lcsd_voxel_mem.sv
// one-bit voxel memory with registered read and a clearing pass after reset
// no package dependency; used by led_cube_scan_driver_unit
`default_nettype none

module lcsd_voxel_mem #(
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  output logic                          ready,
  input  wire logic                     wr_en,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     wdata,
  output logic                          rdata
);

  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  assign ready = !clr_busy;

endmodule

`default_nettype wire

FILE: src/lcsd_checker.sv
// port-level checks of the led cube scan driver, bound to its top level
// uses lcsd_pkg item structs
`default_nettype none

module lcsd_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire lcsd_pkg::res_t res
);

  import lcsd_pkg::*;

  // clearing pass keeps the command side closed right after reset
  a_stall_after_reset: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("command accepted right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result item changed");

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.shift_pulse && res.latch_pulse))
    else $error("shift and latch pulse in one item");

  a_serial_only_shift: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.shift_pulse |-> !res.serial_bit)
    else $error("serial bit without shift pulse");

  a_shift_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.shift_pulse |-> res.busy_res && !(|res.mapped_x) && !(|res.mapped_z))
    else $error("shift item while idle or with coordinates");

endmodule

bind led_cube_scan_driver_unit lcsd_checker u_lcsd_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_stall(cmd_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);

`default_nettype wire
